// ----- rtl/pht_pkg.sv -----
// Shared types, codes and constants of the prefetch history table.
package pht_pkg;

    // Default geometry
    localparam int NUM_SETS_DEF = 64;
    localparam int NUM_WAYS_DEF = 4;

    // Field widths
    localparam int PC_W     = 32;
    localparam int ADDR_W   = 32;
    localparam int OFFSET_W = 8;
    localparam int FP_W     = 64;
    localparam int COUNT_W  = 7;

    // Use counter wraps to zero once it has reached this value
    localparam logic [COUNT_W-1:0] COUNT_WRAP = COUNT_W'(125);
    localparam logic [COUNT_W-1:0] COUNT_FILL = COUNT_W'(1);

    // Commands
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_FILL   = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_MODE   = 1'b1;

    // Set index source
    localparam logic IDX_PC   = 1'b0;
    localparam logic IDX_ADDR = 1'b1;

    // Tag match rules
    localparam logic [2:0] TAG_PC_ADDR   = 3'd0;
    localparam logic [2:0] TAG_PC_OFFSET = 3'd1;
    localparam logic [2:0] TAG_PC        = 3'd2;
    localparam logic [2:0] TAG_ADDR      = 3'd3;
    localparam logic [2:0] TAG_OFFSET    = 3'd4;

    // One stored way: tags and footprint
    typedef struct packed {
        logic [PC_W-1:0]     pc;
        logic [ADDR_W-1:0]   addr;
        logic [OFFSET_W-1:0] offset;
        logic [FP_W-1:0]     footprint;
    } t_entry;

    // Per-way bookkeeping, cleared after reset
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } t_meta;

    // Request fields held while the request is worked on
    typedef struct packed {
        logic                command;
        logic [PC_W-1:0]     pc;
        logic [ADDR_W-1:0]   addr;
        logic [OFFSET_W-1:0] offset;
        logic [FP_W-1:0]     footprint;
    } t_req;

endpackage

// ----- rtl/pht_way_sel.sv -----
// Tag compare, hit way and replacement way choice over one set.
module pht_way_sel
    import pht_pkg::*;
#(
    parameter int NUM_WAYS = NUM_WAYS_DEF,
    parameter int WAY_W    = 2
) (
    input  t_entry [NUM_WAYS-1:0] i_row,
    input  t_meta  [NUM_WAYS-1:0] i_meta,
    input  logic   [2:0]          i_tag_mode,
    input  logic   [PC_W-1:0]     i_pc,
    input  logic   [ADDR_W-1:0]   i_addr,
    input  logic   [OFFSET_W-1:0] i_offset,
    output logic                  o_hit,
    output logic   [WAY_W-1:0]    o_hit_way,
    output logic   [WAY_W-1:0]    o_fill_way
);

    logic [NUM_WAYS-1:0] w_match;
    logic [NUM_WAYS-1:0] w_least;
    logic [NUM_WAYS-1:0] w_invalid;

    // Per-way tag match under the selected rule
    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            unique case (i_tag_mode)
                TAG_PC_ADDR:   w_match[w] = (i_row[w].pc == i_pc) && (i_row[w].addr == i_addr);
                TAG_PC_OFFSET: w_match[w] = (i_row[w].pc == i_pc) &&
                                            (i_row[w].offset == i_offset);
                TAG_PC:        w_match[w] = (i_row[w].pc == i_pc);
                TAG_ADDR:      w_match[w] = (i_row[w].addr == i_addr);
                TAG_OFFSET:    w_match[w] = (i_row[w].offset == i_offset);
                default:       w_match[w] = 1'b0;
            endcase
            w_match[w]   = w_match[w] && i_meta[w].valid;
            w_invalid[w] = !i_meta[w].valid;
        end
    end

    // Way w is the victim candidate if it is strictly below all lower ways
    // and not above any higher way (first smallest count on a tie)
    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_least[w] = 1'b1;
            for (int v = 0; v < NUM_WAYS; v++) begin
                if (v < w && i_meta[v].count <= i_meta[w].count) begin
                    w_least[w] = 1'b0;
                end
                if (v > w && i_meta[v].count < i_meta[w].count) begin
                    w_least[w] = 1'b0;
                end
            end
        end
    end

    // First matching way, first invalid way, else least-used way
    always_comb begin
        o_hit      = |w_match;
        o_hit_way  = '0;
        o_fill_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (w_match[w]) begin
                o_hit_way = WAY_W'(w);
            end
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (w_least[w]) begin
                o_fill_way = WAY_W'(w);
            end
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (w_invalid[w]) begin
                o_fill_way = WAY_W'(w);
            end
        end
    end

endmodule

// ----- rtl/prefetch_history_table.sv -----
// Set-associative prefetch history table: set memories, request sequencer, result register.
//
//  Channel  Dir  Handshake                 Payload
//  in       in   i_in_valid / o_in_stall   i_command, i_pc, i_addr, i_offset, i_footprint_in
//  out      out  o_out_valid / i_out_stall o_hit, o_footprint_out
//  cfg      in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  A request passes four steps: capture, reciprocal multiply for the set index, remainder
//  and set read, then compare and write-back, starting in the cycle the read data returns.
//  After reset the bookkeeping memory is cleared one set per cycle, all NUM_SETS sets,
//  with the input stalled; configuration writes are taken throughout.
//  A lookup result waits in the output register; the next request may start meanwhile,
//  but a lookup whose result register is still held by a stall waits in compare.
module prefetch_history_table
    import pht_pkg::*;
#(
    parameter int NUM_SETS = NUM_SETS_DEF,
    parameter int NUM_WAYS = NUM_WAYS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_command,
    input  logic [PC_W-1:0]       i_pc,
    input  logic [ADDR_W-1:0]     i_addr,
    input  logic [OFFSET_W-1:0]   i_offset,
    input  logic [FP_W-1:0]       i_footprint_in,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_hit,
    output logic [FP_W-1:0]       o_footprint_out,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int LOG_N  = $clog2(NUM_SETS);
    localparam int SHIFT  = 32 + LOG_N;
    // floor(2^SHIFT / NUM_SETS): quotient estimate is low by at most one
    localparam logic [32:0] RECIP = 33'((64'd1 << SHIFT) / NUM_SETS);
    localparam logic [31:0] NSETS = 32'(NUM_SETS);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_SUB   = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;

    // Set memories
    t_entry [NUM_WAYS-1:0] r_data_mem [NUM_SETS];
    t_meta  [NUM_WAYS-1:0] r_meta_mem [NUM_SETS];
    t_entry [NUM_WAYS-1:0] r_data_rd;
    t_meta  [NUM_WAYS-1:0] r_meta_rd;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [SET_W-1:0] r_clr_set;
    logic             r_index_mode;
    logic [2:0]       r_tag_mode;
    t_req             r_req;
    logic [31:0]      r_key;
    logic [31:0]      r_quot;
    logic [SET_W-1:0] r_set;
    logic             r_out_valid;
    logic             r_out_hit;
    logic [FP_W-1:0]  r_out_fp;

    logic             w_accept;
    logic             w_out_free;
    logic [64:0]      w_prod;
    logic [31:0]      w_qn;
    logic [31:0]      w_rem0;
    logic [31:0]      w_rem;
    logic [SET_W-1:0] w_rd_set;
    logic             w_rd_en;
    logic             w_hit;
    logic [WAY_W-1:0] w_hit_way;
    logic [WAY_W-1:0] w_fill_way;
    logic             w_data_we;
    logic             w_meta_we;
    logic [SET_W-1:0] w_meta_set;
    t_entry [NUM_WAYS-1:0] w_data_wr;
    t_meta  [NUM_WAYS-1:0] w_meta_wr;
    logic             w_done;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_mode <= IDX_PC;
            r_tag_mode   <= TAG_PC_ADDR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_INDEX_MODE: r_index_mode <= i_cfg_data[0];
                CFG_TAG_MODE:   r_tag_mode   <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // Set index: key mod NUM_SETS by reciprocal multiply and one correction
    assign w_prod   = 65'(r_key) * 65'(RECIP);
    assign w_qn     = 32'(r_quot * NSETS);
    assign w_rem0   = r_key - w_qn;
    assign w_rem    = (w_rem0 >= NSETS) ? (w_rem0 - NSETS) : w_rem0;
    assign w_rd_set = w_rem[SET_W-1:0];
    assign w_rd_en  = (r_state == ST_SUB);

    // Request capture and index pipeline registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.command   <= i_command;
            r_req.pc        <= i_pc;
            r_req.addr      <= i_addr;
            r_req.offset    <= i_offset;
            r_req.footprint <= i_footprint_in;
            r_key           <= (r_index_mode == IDX_ADDR) ? i_addr : i_pc;
        end
        if (r_state == ST_MUL) begin
            r_quot <= 32'(w_prod >> SHIFT);
        end
        if (w_rd_en) begin
            r_set <= w_rd_set;
        end
    end

    // Synchronous reads into the read registers
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_data_rd <= r_data_mem[w_rd_set];
            r_meta_rd <= r_meta_mem[w_rd_set];
        end
    end

    pht_way_sel #(
        .NUM_WAYS (NUM_WAYS),
        .WAY_W    (WAY_W)
    ) u_way_sel (
        .i_row      (r_data_rd),
        .i_meta     (r_meta_rd),
        .i_tag_mode (r_tag_mode),
        .i_pc       (r_req.pc),
        .i_addr     (r_req.addr),
        .i_offset   (r_req.offset),
        .o_hit      (w_hit),
        .o_hit_way  (w_hit_way),
        .o_fill_way (w_fill_way)
    );

    // Write-back: after reset clear zeroes bookkeeping, fill replaces one way, a lookup hit bumps its counter
    assign w_done = (r_state == ST_CMP) && ((r_req.command == CMD_FILL) || w_out_free);

    always_comb begin
        w_data_wr  = r_data_rd;
        w_meta_wr  = r_meta_rd;
        w_data_we  = 1'b0;
        w_meta_we  = 1'b0;
        w_meta_set = r_set;
        if (r_state == ST_CLEAR) begin
            w_meta_wr  = '0;
            w_meta_we  = 1'b1;
            w_meta_set = r_clr_set;
        end else if (w_done) begin
            if (r_req.command == CMD_FILL) begin
                w_data_wr[w_fill_way].pc        = r_req.pc;
                w_data_wr[w_fill_way].addr      = r_req.addr;
                w_data_wr[w_fill_way].offset    = r_req.offset;
                w_data_wr[w_fill_way].footprint = r_req.footprint;
                w_meta_wr[w_fill_way].valid     = 1'b1;
                w_meta_wr[w_fill_way].count     = COUNT_FILL;
                w_data_we = 1'b1;
                w_meta_we = 1'b1;
            end else if (w_hit) begin
                w_meta_wr[w_hit_way].count =
                    (r_meta_rd[w_hit_way].count >= COUNT_WRAP) ? '0
                    : r_meta_rd[w_hit_way].count + COUNT_W'(1);
                w_meta_we = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_data_we) begin
            r_data_mem[r_set] <= w_data_wr;
        end
        if (w_meta_we) begin
            r_meta_mem[w_meta_set] <= w_meta_wr;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_set == SET_W'(NUM_SETS - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (w_accept) n_state = ST_MUL;
            ST_MUL:   n_state = ST_SUB;
            ST_SUB:   n_state = ST_CMP;
            ST_CMP:   if (w_done) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_set <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_set <= r_clr_set + SET_W'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done && r_req.command == CMD_LOOKUP) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && r_req.command == CMD_LOOKUP) begin
            r_out_hit <= w_hit;
            r_out_fp  <= w_hit ? r_data_rd[w_hit_way].footprint : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_footprint_out = r_out_fp;

endmodule

// ----- bench/prefetch_history_table_test.sv -----
// Self-checking testbench of the prefetch history table: directed table, use counter wrap, then random traffic.
`timescale 1ns / 100ps

module prefetch_history_table_test
    import pht_pkg::*;
();

    localparam int NUM_SETS     = NUM_SETS_DEF;
    localparam int NUM_WAYS     = NUM_WAYS_DEF;
    localparam int SET_BITS     = $clog2(NUM_SETS);
    localparam int RESET_CYCLES = 6;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 50;
    localparam int RECENT_DEPTH = 24;
    localparam int NUM_PHASES   = 8;

    // Tag rules with no meaning: every lookup misses
    localparam logic [2:0] TAG_RSVD5 = 3'd5;
    localparam logic [2:0] TAG_RSVD6 = 3'd6;
    localparam logic [2:0] TAG_RSVD7 = 3'd7;

    typedef struct packed {
        logic            hit;
        logic [FP_W-1:0] footprint;
    } t_lookup_result;

    typedef struct {
        t_req           req;
        bit             known;
        t_lookup_result want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_command;
    logic [PC_W-1:0]       i_pc;
    logic [ADDR_W-1:0]     i_addr;
    logic [OFFSET_W-1:0]   i_offset;
    logic [FP_W-1:0]       i_footprint_in;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_hit;
    logic [FP_W-1:0]       o_footprint_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Shadow copy of the table and its settings
    bit                 tbl_valid     [NUM_SETS][NUM_WAYS];
    bit [PC_W-1:0]      tbl_pc        [NUM_SETS][NUM_WAYS];
    bit [ADDR_W-1:0]    tbl_addr      [NUM_SETS][NUM_WAYS];
    bit [OFFSET_W-1:0]  tbl_offset    [NUM_SETS][NUM_WAYS];
    bit [FP_W-1:0]      tbl_footprint [NUM_SETS][NUM_WAYS];
    bit [COUNT_W-1:0]   tbl_count     [NUM_SETS][NUM_WAYS];
    bit                 sh_index_addr;
    bit [2:0]           sh_tag_rule;

    t_lookup_result expected_lookups[$];
    t_lookup_result want;
    t_dir_row       dir_rows[$];

    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned lookups_sent;
    int unsigned hits_predicted;
    int unsigned fills_sent;
    int unsigned settings_used;
    int unsigned burst_left;
    int unsigned stall_hold;

    prefetch_history_table DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_pc           (i_pc),
        .i_addr         (i_addr),
        .i_offset       (i_offset),
        .i_footprint_in (i_footprint_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_footprint_out(o_footprint_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one request to the shadow table; returns the lookup outcome
    function automatic t_lookup_result apply_to_table(input t_req r);
        int unsigned        s;
        int unsigned        victim;
        bit                 found;
        bit                 match;
        bit [COUNT_W-1:0]   least;
        t_lookup_result     res;
        res = '0;
        found = 1'b0;
        victim = 0;
        s = sh_index_addr ? (r.addr % NUM_SETS) : (r.pc % NUM_SETS);
        if (r.command == CMD_FILL) begin
            // first empty way, else least used, lowest way on a tie
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (!found && !tbl_valid[s][w]) begin
                    victim = w;
                    found = 1'b1;
                end
            end
            if (!found) begin
                least = '1;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    if (tbl_count[s][w] < least) begin
                        least = tbl_count[s][w];
                        victim = w;
                    end
                end
            end
            tbl_valid[s][victim]     = 1'b1;
            tbl_pc[s][victim]        = r.pc;
            tbl_addr[s][victim]      = r.addr;
            tbl_offset[s][victim]    = r.offset;
            tbl_footprint[s][victim] = r.footprint;
            tbl_count[s][victim]     = COUNT_FILL;
        end else begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                case (sh_tag_rule)
                    TAG_PC_ADDR:   match = tbl_pc[s][w] == r.pc && tbl_addr[s][w] == r.addr;
                    TAG_PC_OFFSET: match = tbl_pc[s][w] == r.pc && tbl_offset[s][w] == r.offset;
                    TAG_PC:        match = tbl_pc[s][w] == r.pc;
                    TAG_ADDR:      match = tbl_addr[s][w] == r.addr;
                    TAG_OFFSET:    match = tbl_offset[s][w] == r.offset;
                    default:       match = 1'b0;
                endcase
                if (!found && tbl_valid[s][w] && match) begin
                    found = 1'b1;
                    // use counter wraps to zero once it has reached the wrap value
                    if (tbl_count[s][w] >= COUNT_WRAP) begin
                        tbl_count[s][w] = '0;
                    end else begin
                        tbl_count[s][w] = tbl_count[s][w] + 1'b1;
                    end
                    res.hit = 1'b1;
                    res.footprint = tbl_footprint[s][w];
                end
            end
        end
        return res;
    endfunction

    function automatic void add_row(input logic cmd, input logic [PC_W-1:0] pc,
                                    input logic [ADDR_W-1:0] addr,
                                    input logic [OFFSET_W-1:0] off, input logic [FP_W-1:0] fp,
                                    input bit known = 1'b0, input logic hit = 1'b0,
                                    input logic [FP_W-1:0] fp_out = '0);
        t_dir_row row;
        row.req.command   = cmd;
        row.req.pc        = pc;
        row.req.addr      = addr;
        row.req.offset    = off;
        row.req.footprint = fp;
        row.known         = known;
        row.want.hit      = hit;
        row.want.footprint = fp_out;
        dir_rows.push_back(row);
    endfunction

    // Send one request in bursts with random gaps, then record its expected outcome
    task automatic issue(input t_req r, input bit known, input t_lookup_result typed);
        t_lookup_result predicted;
        int unsigned    gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_command      <= r.command;
        i_pc           <= r.pc;
        i_addr         <= r.addr;
        i_offset       <= r.offset;
        i_footprint_in <= r.footprint;
        do @(posedge i_clk); while (o_in_stall);
        predicted = apply_to_table(r);
        if (r.command == CMD_LOOKUP) begin
            expected_lookups.push_back(known ? typed : predicted);
            lookups_sent++;
            hits_predicted += predicted.hit;
        end else begin
            fills_sent++;
        end
    endtask

    // Hold the sender until every lookup has returned, then let fills finish
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_lookups.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both mode registers back to back; unused data bits are random
    task automatic write_config(input bit index_addr, input logic [2:0] tag_rule);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        data[0] = index_addr;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_INDEX_MODE;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sh_index_addr = index_addr;
        i_cfg_index <= CFG_TAG_MODE;
        i_cfg_data  <= tag_rule;
        do @(posedge i_clk); while (!o_cfg_ready);
        sh_tag_rule = tag_rule;
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Cycle limit, result checking and the receiver's stall pattern
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d lookups outstanding",
                     cycle_count, expected_lookups.size());
            $display("tb: failure");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (expected_lookups.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result: hit %0b footprint %h", o_hit, o_footprint_out);
                end
            end else begin
                want = expected_lookups.pop_front();
                if (o_hit !== want.hit || o_footprint_out !== want.footprint) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d: hit exp %0b got %0b, footprint exp %h got %h",
                                 results_checked, want.hit, o_hit, want.footprint,
                                 o_footprint_out);
                    end
                end
            end
        end
        // stall pattern follows bits 9:8 of the cycle count
        case (cycle_count[9:8])
            2'd0: i_out_stall <= 1'b0;
            2'd1: i_out_stall <= ($urandom_range(0, 1) == 0);
            2'd2: i_out_stall <= (cycle_count % 5) < 2;
            default: begin
                if (stall_hold != 0) begin
                    stall_hold <= stall_hold - 1;
                end else begin
                    i_out_stall <= ~i_out_stall;
                    stall_hold <= $urandom_range(0, 12);
                end
            end
        endcase
    end

    initial begin
        t_req           r;
        t_req           pick;
        t_req           hammer_keys[NUM_WAYS];
        t_req           recent[$];
        logic [SET_BITS-1:0] hot;
        logic [SET_BITS-1:0] hot_sets[4];
        bit             phase_index[NUM_PHASES];
        logic [2:0]     phase_tag[NUM_PHASES];
        int unsigned    roll;

        phase_index = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        phase_tag   = '{TAG_ADDR, TAG_PC_OFFSET, TAG_PC, TAG_OFFSET,
                        TAG_RSVD5, TAG_RSVD6, TAG_RSVD7, TAG_PC_ADDR};
        cycle_count = 0;
        mismatches = 0;
        results_checked = 0;
        lookups_sent = 0;
        hits_predicted = 0;
        fills_sent = 0;
        settings_used = 0;
        burst_left = 0;
        stall_hold = 0;
        sh_index_addr = IDX_PC;
        sh_tag_rule = TAG_PC_ADDR;

        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_command      <= CMD_LOOKUP;
        i_pc           <= '0;
        i_addr         <= '0;
        i_offset       <= '0;
        i_footprint_in <= '0;
        i_out_stall    <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_INDEX_MODE;
        i_cfg_data     <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows under the reset settings: set from pc, tag is pc and addr
        add_row(CMD_LOOKUP, '0, '0, '0, '0, 1'b1, 1'b0, '0);   // empty table
        add_row(CMD_LOOKUP, '1, '1, '1, '1, 1'b1, 1'b0, '0);
        add_row(CMD_FILL,   '0, '0, '0, '1);
        add_row(CMD_LOOKUP, '0, '0, '0, '0, 1'b1, 1'b1, '1);
        add_row(CMD_FILL,   '1, '1, '1, '0);
        add_row(CMD_LOOKUP, '1, '1, '1, '1, 1'b1, 1'b1, '0);
        add_row(CMD_LOOKUP, '1, '0, '1, '0, 1'b1, 1'b0, '0);   // pc alone does not match
        add_row(CMD_LOOKUP, '0, '1, '0, '0, 1'b1, 1'b0, '0);   // pc alone does not match here either
        // fill all ways of set 5
        add_row(CMD_FILL, 32'h05, 32'h1000, 8'h00, 64'hAAAA_AAAA_AAAA_AAAA);
        add_row(CMD_FILL, 32'h45, 32'h1001, 8'h01, 64'h5555_5555_5555_5555);
        add_row(CMD_FILL, 32'h85, 32'h1002, 8'h02, 64'h0123_4567_89AB_CDEF);
        add_row(CMD_FILL, 32'hC5, 32'h1003, 8'h03, 64'hFEDC_BA98_7654_3210);
        add_row(CMD_LOOKUP, 32'h85, 32'h1002, 8'h7F, '0, 1'b1, 1'b1, 64'h0123_4567_89AB_CDEF);
        // set full: least used way goes, lowest way on a tie
        add_row(CMD_FILL,   32'h105, 32'h2000, 8'h80, 64'h8000_0000_0000_0001);
        add_row(CMD_LOOKUP, 32'h05,  32'h1000, 8'h00, '0);
        add_row(CMD_LOOKUP, 32'h105, 32'h2000, 8'h00, '0);
        // same line filled again lands in a further way
        add_row(CMD_FILL,   32'h105, 32'h2000, 8'h81, 64'h0F0F_0F0F_0F0F_0F0F);
        add_row(CMD_LOOKUP, 32'h105, 32'h2000, 8'h00, '0);
        add_row(CMD_LOOKUP, 32'h45,  32'h1001, 8'h01, '0);
        add_row(CMD_LOOKUP, 32'hC5,  32'h1003, 8'h00, '0);
        foreach (dir_rows[i]) begin
            issue(dir_rows[i].req, dir_rows[i].known, dir_rows[i].want);
        end

        // Use counter wrap: fill a set, hit the first line filled until its counter returns to zero,
        // then the next fill must replace it
        hot = SET_BITS'($urandom);
        for (int k = 0; k < NUM_WAYS; k++) begin
            r.command = CMD_FILL;
            r.pc = $urandom;
            r.pc[SET_BITS-1:0] = hot;
            r.addr = $urandom;
            r.offset = OFFSET_W'($urandom);
            r.footprint = {$urandom, $urandom};
            hammer_keys[k] = r;
            issue(r, 1'b0, '0);
        end
        r = hammer_keys[0];
        r.command = CMD_LOOKUP;
        repeat (int'(COUNT_WRAP)) issue(r, 1'b0, '0);
        r.command = CMD_FILL;
        r.pc = $urandom;
        r.pc[SET_BITS-1:0] = hot;
        r.addr = $urandom;
        r.footprint = {$urandom, $urandom};
        issue(r, 1'b0, '0);
        r.command = CMD_LOOKUP;
        issue(r, 1'b0, '0);
        issue(hammer_keys[0], 1'b0, '0);

        // Random traffic, one block per setting, concentrated on a few sets
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_and_settle();
            write_config(phase_index[p], phase_tag[p]);
            foreach (hot_sets[j]) hot_sets[j] = SET_BITS'($urandom);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                r.pc = $urandom;
                r.addr = $urandom;
                r.offset = OFFSET_W'($urandom);
                r.footprint = {$urandom, $urandom};
                if ($urandom_range(0, 99) < 85) begin
                    r.pc[SET_BITS-1:0] = hot_sets[$urandom_range(0, 3)];
                    r.addr[SET_BITS-1:0] = hot_sets[$urandom_range(0, 3)];
                end
                if (roll < 35) begin
                    r.command = CMD_FILL;
                    // sometimes refill a line that is already present
                    if (recent.size() != 0 && $urandom_range(0, 2) == 0) begin
                        pick = recent[$urandom_range(0, recent.size() - 1)];
                        r.pc = pick.pc;
                        r.addr = pick.addr;
                        if ($urandom_range(0, 1) == 0) r.offset = pick.offset;
                    end
                end else begin
                    r.command = CMD_LOOKUP;
                    if (recent.size() != 0 && roll < 90) begin
                        pick = recent[$urandom_range(0, recent.size() - 1)];
                        r.pc = pick.pc;
                        r.addr = pick.addr;
                        r.offset = pick.offset;
                        // partial matches: one tag field replaced
                        if (roll >= 72) begin
                            case ($urandom_range(0, 2))
                                0:       r.pc = $urandom;
                                1:       r.addr = $urandom;
                                default: r.offset = OFFSET_W'($urandom);
                            endcase
                        end
                    end
                end
                issue(r, 1'b0, '0);
                if (r.command == CMD_FILL) begin
                    recent.push_back(r);
                    if (recent.size() > RECENT_DEPTH) void'(recent.pop_front());
                end
            end
        end

        drain_and_settle();
        $display("ran %0d lookups (%0d hits) and %0d fills across %0d mode settings",
                 lookups_sent, hits_predicted, fills_sent, settings_used + 1);
        $display("including eviction ties, refills of present lines and a use counter wrap");
        if (mismatches == 0 && expected_lookups.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatching results", mismatches);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
